/* hw/rtl/irpd_pkg.sv */
// irpd_pkg: shared types, constants and the command lookup for the
// pulse-distance ir decoder. no dependencies.

package irpd_pkg;

  // frame geometry
  localparam int FRAME_BITS = 32;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = $clog2(FRAME_BITS + 1);
  localparam int TICK_W     = 8;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CNT_W-1:0] CNT_IDLE = CNT_W'(FRAME_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LOW     = 3'd0,
    REG_START_HIGH    = 3'd1,
    REG_REPEAT_LOW    = 3'd2,
    REG_REPEAT_HIGH   = 3'd3,
    REG_BIT_MAX       = 3'd4,
    REG_ONE_THRESHOLD = 3'd5
  } cfg_reg_t;

  // reset values of the thresholds
  localparam logic [TICK_W-1:0] START_LOW_RST     = 8'd201;
  localparam logic [TICK_W-1:0] START_HIGH_RST    = 8'd221;
  localparam logic [TICK_W-1:0] REPEAT_LOW_RST    = 8'd166;
  localparam logic [TICK_W-1:0] REPEAT_HIGH_RST   = 8'd186;
  localparam logic [TICK_W-1:0] BIT_MAX_RST       = 8'd40;
  localparam logic [TICK_W-1:0] ONE_THRESHOLD_RST = 8'd26;

  // event codes
  typedef enum logic [2:0] {
    EV_BIT    = 3'd0,
    EV_START  = 3'd1,
    EV_REPEAT = 3'd2,
    EV_REJECT = 3'd3,
    EV_DONE   = 3'd4
  } event_kind_t;

  // motor commands
  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_FORWARD      = 3'd1,
    CMD_BACKWARD     = 3'd2,
    CMD_STOP         = 3'd3,
    CMD_CRAB_LEFT    = 3'd4,
    CMD_CRAB_RIGHT   = 3'd5,
    CMD_ROTATE_LEFT  = 3'd6,
    CMD_ROTATE_RIGHT = 3'd7
  } motor_cmd_t;

  // received word to motor command, unknown words give none
  function automatic motor_cmd_t match_command(input logic [WORD_W-1:0] word);
    motor_cmd_t cmd;
    unique case (word)
      32'h00FF18E7: cmd = CMD_FORWARD;
      32'h00FF4AB5: cmd = CMD_BACKWARD;
      32'h00FF38C7: cmd = CMD_STOP;
      32'h00FF10EF: cmd = CMD_CRAB_LEFT;
      32'h00FF5AA5: cmd = CMD_CRAB_RIGHT;
      32'h00FF6897: cmd = CMD_ROTATE_LEFT;
      32'h00FFB04F: cmd = CMD_ROTATE_RIGHT;
      default:      cmd = CMD_NONE;
    endcase
    return cmd;
  endfunction

endpackage

/* hw/rtl/ir_pulse_distance_decoder_unit.sv */
// ir_pulse_distance_decoder_unit: top level of the pulse-distance ir decoder,
// frame state, threshold registers and a two-entry output buffer.
// depends on irpd_pkg.
//
// usage
//   input channel: one beat per falling ir edge, interval_ticks and
//   timer_overflowed, taken when in_valid is high and in_stall is low.
//   output channel: one beat per input beat, event_kind, frame_word and
//   motor_command, taken when out_valid is high and out_stall is low.
//   configuration: cfg_we writes cfg_data into threshold register cfg_index
//   in that cycle; indexes past the last register are ignored.
// timing
//   each beat's result is registered in the output register, or in the skid
//   register while the output is stalled. one beat per cycle is sustained
//   while out_stall is low, set by the single compare-and-shift stage.
// reset
//   rst is synchronous; it sets the thresholds to their defaults, the frame
//   logic to idle awaiting a start interval, clears the shift word and
//   empties the output buffer.
// stalls
//   a second result is held in a skid register while the output is stalled;
//   in_stall rises only once both output entries are full.

module ir_pulse_distance_decoder_unit
  import irpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [TICK_W-1:0]    interval_ticks,
  input  logic                 timer_overflowed,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           event_kind,
  output logic [WORD_W-1:0]    frame_word,
  output logic [2:0]           motor_command,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  // threshold registers
  logic [TICK_W-1:0] start_low;
  logic [TICK_W-1:0] start_high;
  logic [TICK_W-1:0] repeat_low;
  logic [TICK_W-1:0] repeat_high;
  logic [TICK_W-1:0] bit_max;
  logic [TICK_W-1:0] one_threshold;

  // frame state
  logic [CNT_W-1:0]  bit_counter;
  logic [CNT_W-1:0]  bit_counter_next;
  logic [WORD_W-1:0] shift_word;
  logic [WORD_W-1:0] shift_word_next;

  // result of the current beat
  event_kind_t       kind_next;
  motor_cmd_t        cmd_next;

  // output buffer
  logic              skid_valid;
  event_kind_t       skid_kind;
  logic [WORD_W-1:0] skid_word;
  motor_cmd_t        skid_cmd;

  logic in_beat;
  logic out_beat;
  logic is_idle;
  logic start_hit;
  logic repeat_hit;
  logic data_bad;
  logic data_bit;

  assign in_stall = skid_valid;
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_low     <= START_LOW_RST;
      start_high    <= START_HIGH_RST;
      repeat_low    <= REPEAT_LOW_RST;
      repeat_high   <= REPEAT_HIGH_RST;
      bit_max       <= BIT_MAX_RST;
      one_threshold <= ONE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_LOW:     start_low     <= cfg_data;
        REG_START_HIGH:    start_high    <= cfg_data;
        REG_REPEAT_LOW:    repeat_low    <= cfg_data;
        REG_REPEAT_HIGH:   repeat_high   <= cfg_data;
        REG_BIT_MAX:       bit_max       <= cfg_data;
        REG_ONE_THRESHOLD: one_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // interval classification, all interval compares strict
  assign is_idle    = bit_counter >= CNT_IDLE;
  assign start_hit  = (interval_ticks > start_low) && (interval_ticks < start_high)
                      && !timer_overflowed;
  assign repeat_hit = (interval_ticks > repeat_low) && (interval_ticks < repeat_high)
                      && !timer_overflowed;
  assign data_bad   = (interval_ticks > bit_max) || timer_overflowed;
  assign data_bit   = interval_ticks > one_threshold;

  // next frame state and result
  always_comb begin
    bit_counter_next = bit_counter;
    shift_word_next  = shift_word;
    kind_next        = EV_REJECT;
    cmd_next         = CMD_NONE;
    if (is_idle) begin
      priority if (start_hit) begin
        shift_word_next  = '0;
        bit_counter_next = '0;
        kind_next        = EV_START;
      end else if (repeat_hit) begin
        kind_next        = EV_REPEAT;
      end else begin
        bit_counter_next = CNT_IDLE;
        kind_next        = EV_REJECT;
      end
    end else if (data_bad) begin
      bit_counter_next = CNT_IDLE;
      kind_next        = EV_REJECT;
    end else begin
      shift_word_next = {shift_word[WORD_W-2:0], data_bit};
      if (bit_counter == CNT_LAST) begin
        cmd_next         = match_command(shift_word_next);
        bit_counter_next = CNT_IDLE;
        kind_next        = EV_DONE;
      end else begin
        bit_counter_next = bit_counter + CNT_W'(1);
        kind_next        = EV_BIT;
      end
    end
  end

  // frame state update on each input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_counter <= CNT_IDLE;
      shift_word  <= '0;
    end else if (in_beat) begin
      bit_counter <= bit_counter_next;
      shift_word  <= shift_word_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_beat) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (in_beat) begin
      if (out_valid && !out_beat) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid  <= 1'b1;
      end
    end else if (out_beat) begin
      out_valid <= 1'b0;
    end
  end

  // payload of the output buffer
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_beat) begin
        event_kind    <= skid_kind;
        frame_word    <= skid_word;
        motor_command <= skid_cmd;
      end
    end else if (in_beat) begin
      if (out_valid && !out_beat) begin
        skid_kind <= kind_next;
        skid_word <= shift_word_next;
        skid_cmd  <= cmd_next;
      end else begin
        event_kind    <= kind_next;
        frame_word    <= shift_word_next;
        motor_command <= cmd_next;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (in_beat && kind_next == EV_DONE) |=> bit_counter == CNT_IDLE)
    else $error("frame complete did not return to idle");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_beat && kind_next == EV_START) |=> (bit_counter == '0 && shift_word == '0))
    else $error("start interval did not arm reception");

  a_cmd_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motor_command != CMD_NONE) |-> event_kind == EV_DONE)
    else $error("motor command outside frame complete");

endmodule
